[rtl/gcpd_pkg.sv]
// Shared types and constants for the Gray-code pattern decoder.
package gcpd_pkg;

	localparam int PIX_W    = 19;
	localparam int PAT_W    = 4;
	localparam int BYTE_W   = 8;
	localparam int SUM_W    = 10;
	localparam int THR_W    = 11;
	localparam int CFG_CNT_W = 4;
	localparam int CNT_W    = 5;
	localparam int STRIPE_W = 10;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;
	localparam int IN_DW    = 72;
	localparam int OUT_DW   = 32;

	localparam int DEF_MAX_PIXELS = 524288;
	localparam int DEF_MAX_BITS   = 10;

	localparam logic [CFG_CNT_W-1:0] CNT_RESET = 4'd9;

	typedef enum logic [1:0] {
		REG_WHITE = 2'd0,
		REG_BLACK = 2'd1,
		REG_COUNT = 2'd2
	} reg_idx_t;

	// control half of a pipeline stage
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [PIX_W-1:0] pix;
	} item_ctl_t;

	typedef struct packed {
		logic [PAT_W-1:0] pat;
		logic [SUM_W-1:0] pos_sum;
		logic [SUM_W-1:0] neg_sum;
	} s1_data_t;

endpackage

[rtl/gcpd_ingest.sv]
// Stage 1: range and pattern checks, colour sums.
module gcpd_ingest import gcpd_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS,
	parameter int MAX_BITS   = DEF_MAX_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [PIX_W-1:0]     pixel_index,
	input  logic [PAT_W-1:0]     pattern_index,
	input  logic [BYTE_W-1:0]    pos_red,
	input  logic [BYTE_W-1:0]    pos_green,
	input  logic [BYTE_W-1:0]    pos_blue,
	input  logic [BYTE_W-1:0]    neg_red,
	input  logic [BYTE_W-1:0]    neg_green,
	input  logic [BYTE_W-1:0]    neg_blue,
	input  logic [CFG_CNT_W-1:0] pattern_count,
	output item_ctl_t            ctl_s1,
	output s1_data_t             data_s1
);

	localparam logic [31:0]      PixLimit = 32'(MAX_PIXELS);
	localparam logic [CNT_W-1:0] BitsMax  = CNT_W'(MAX_BITS);

	logic [CNT_W-1:0] cnt_eff;
	logic [CNT_W-1:0] pat_ext;
	logic             keep;
	logic             last;

	always_comb begin
		cnt_eff = {1'b0, pattern_count};
		if (pattern_count == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (cnt_eff > BitsMax) begin
			cnt_eff = BitsMax;
		end
	end

	assign pat_ext = {1'b0, pattern_index};
	assign keep = (pat_ext < cnt_eff) && (32'(pixel_index) < PixLimit);
	assign last = (pat_ext + CNT_W'(1)) == cnt_eff;

	// ignored items are dropped here as bubbles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid && keep;
			ctl_s1.last  <= last;
			ctl_s1.pix   <= pixel_index;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.pat      <= pattern_index;
			data_s1.pos_sum  <= SUM_W'(pos_red) + SUM_W'(pos_green) + SUM_W'(pos_blue);
			data_s1.neg_sum  <= SUM_W'(neg_red) + SUM_W'(neg_green) + SUM_W'(neg_blue);
		end
	end

endmodule

[rtl/gcpd_code_mem.sv]
// Per-pixel code store: one write port, one registered read port.
module gcpd_code_mem import gcpd_pkg::*; #(
	parameter int DEPTH = DEF_MAX_PIXELS,
	parameter int AW    = 19,
	parameter int EW    = DEF_MAX_BITS + 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [EW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data
);

	logic [EW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read during write returns the old entry; forwarding covers it
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/gcpd_classify.sv]
// Stages 2 and 3: forwarding, threshold test and code update.
module gcpd_classify import gcpd_pkg::*; #(
	parameter int MAX_BITS = DEF_MAX_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  item_ctl_t               ctl_s1,
	input  s1_data_t                data_s1,
	input  logic [MAX_BITS:0]       rd_data,
	input  logic signed [THR_W-1:0] lit_level,
	input  logic signed [THR_W-1:0] dark_level,
	output logic                    wr_en,
	output logic [PIX_W-1:0]        wr_pix,
	output logic [MAX_BITS:0]       wr_data,
	output item_ctl_t               ctl_s3,
	output logic [MAX_BITS:0]       entry_s3
);

	localparam int EW = MAX_BITS + 1;

	item_ctl_t               ctl_s2;
	logic [PAT_W-1:0]        pat_s2;
	logic signed [THR_W-1:0] diff_s2;
	logic [EW-1:0]           old_s2;

	logic signed [THR_W-1:0] diff;
	logic [EW-1:0]           fwd;
	logic [EW-1:0]           base;
	logic [MAX_BITS-1:0]     code_sh;
	logic [EW-1:0]           new_entry;

	assign diff = signed'({1'b0, data_s1.pos_sum}) - signed'({1'b0, data_s1.neg_sum});

	// youngest older writer wins: stage 2 now, then stage 3 (written at read edge)
	always_comb begin
		if (ctl_s2.valid && ctl_s2.pix == ctl_s1.pix) begin
			fwd = new_entry;
		end else if (ctl_s3.valid && ctl_s3.pix == ctl_s1.pix) begin
			fwd = entry_s3;
		end else begin
			fwd = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pat_s2      <= data_s1.pat;
			diff_s2     <= diff;
			old_s2      <= fwd;
			entry_s3    <= new_entry;
		end
	end

	// pattern zero starts afresh; once flagged a pixel stays flagged
	always_comb begin
		base    = (pat_s2 == '0) ? '0 : old_s2;
		code_sh = base[MAX_BITS-1:0] << 1;
		if (base[MAX_BITS]) begin
			new_entry = {1'b1, {MAX_BITS{1'b0}}};
		end else if (diff_s2 > lit_level) begin
			new_entry = {1'b0, code_sh | MAX_BITS'(1)};
		end else if (diff_s2 < dark_level) begin
			new_entry = {1'b0, code_sh};
		end else begin
			new_entry = {1'b1, {MAX_BITS{1'b0}}};
		end
	end

	assign wr_en   = en && ctl_s2.valid;
	assign wr_pix  = ctl_s2.pix;
	assign wr_data = new_entry;

endmodule

[rtl/gcpd_convert.sv]
// Gray to binary conversion and output register.
module gcpd_convert import gcpd_pkg::*; #(
	parameter int MAX_BITS = DEF_MAX_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  item_ctl_t           ctl_s3,
	input  logic [MAX_BITS:0]   entry_s3,
	output logic                out_valid,
	output logic [PIX_W-1:0]    out_pixel,
	output logic                code_valid,
	output logic [STRIPE_W-1:0] stripe_position
);

	logic [MAX_BITS-1:0] bin;
	logic                ok;

	// each binary bit is the XOR of all Gray bits at or above it
	always_comb begin
		for (int i = 0; i < MAX_BITS; i++) begin
			bin[i] = ^(entry_s3[MAX_BITS-1:0] >> i);
		end
	end

	assign ok = !entry_s3[MAX_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_s3.valid && ctl_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pixel       <= ctl_s3.pix;
			code_valid      <= ok;
			stripe_position <= ok ? STRIPE_W'(bin) : '0;
		end
	end

endmodule

[rtl/gray_code_pattern_decoder_top.sv]
// Top level of the Gray-code pattern decoder: config registers and pipeline.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata: pixel and colour bytes, tuser: pattern index
// m_axis    out  tvalid/tready        tdata: pixel and stripe, tuser: code valid
// apb       in   psel/penable/pready  thresholds and pattern count
//
// One word per cycle in and out unless m_axis_tready stalls; the result word is offered from the output register.
// Stages: sums and store read, threshold test and store write, convert, output.
// Same-pixel hazards are met by forwarding from the two later stages.
// A full output register held by m_axis_tready freezes every stage at once.
// The code store has no reset and no clearing pass; pattern zero rewrites it.
module gray_code_pattern_decoder_top import gcpd_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS,
	parameter int MAX_BITS   = DEF_MAX_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// [18:0] pixel_index, [26:19] pos_red, [34:27] pos_green, [42:35] pos_blue,
	// [50:43] neg_red, [58:51] neg_green, [66:59] neg_blue, [71:67] zero
	input  logic [IN_DW-1:0]  s_axis_tdata,
	// [3:0] pattern_index
	input  logic [PAT_W-1:0]  s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [18:0] out_pixel, [28:19] stripe_position, [31:29] zero
	output logic [OUT_DW-1:0] m_axis_tdata,
	// [0] code_valid
	output logic              m_axis_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int EW = MAX_BITS + 1;

	logic signed [THR_W-1:0] white_q;
	logic signed [THR_W-1:0] black_q;
	logic [CFG_CNT_W-1:0]    count_q;
	reg_idx_t                reg_sel;
	logic                    cfg_wr;

	logic                en;
	item_ctl_t           ctl_s1;
	s1_data_t            data_s1;
	logic [EW-1:0]       rd_data;
	logic                wr_en;
	logic [PIX_W-1:0]    wr_pix;
	logic [EW-1:0]       wr_data;
	item_ctl_t           ctl_s3;
	logic [EW-1:0]       entry_s3;
	logic [PIX_W-1:0]    out_pixel;
	logic                code_valid;
	logic [STRIPE_W-1:0] stripe_position;

	// configuration
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= '0;
			black_q <= '0;
			count_q <= CNT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WHITE: white_q <= pwdata[THR_W-1:0];
				REG_BLACK: black_q <= pwdata[THR_W-1:0];
				REG_COUNT: count_q <= pwdata[CFG_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WHITE: prdata = APB_DW'(white_q);
			REG_BLACK: prdata = APB_DW'(black_q);
			REG_COUNT: prdata = APB_DW'(count_q);
			default:   prdata = '0;
		endcase
	end

	// whole pipeline moves together
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	gcpd_ingest #(
		.MAX_PIXELS (MAX_PIXELS),
		.MAX_BITS   (MAX_BITS)
	) u_ingest (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_axis_tvalid),
		.pixel_index   (s_axis_tdata[18:0]),
		.pattern_index (s_axis_tuser),
		.pos_red       (s_axis_tdata[26:19]),
		.pos_green     (s_axis_tdata[34:27]),
		.pos_blue      (s_axis_tdata[42:35]),
		.neg_red       (s_axis_tdata[50:43]),
		.neg_green     (s_axis_tdata[58:51]),
		.neg_blue      (s_axis_tdata[66:59]),
		.pattern_count (count_q),
		.ctl_s1        (ctl_s1),
		.data_s1       (data_s1)
	);

	gcpd_code_mem #(
		.DEPTH (MAX_PIXELS),
		.AW    (AW),
		.EW    (EW)
	) u_mem (
		.clk     (clk),
		.rd_en   (en),
		.rd_addr (AW'(s_axis_tdata[18:0])),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (AW'(wr_pix)),
		.wr_data (wr_data)
	);

	gcpd_classify #(
		.MAX_BITS (MAX_BITS)
	) u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_s1     (ctl_s1),
		.data_s1    (data_s1),
		.rd_data    (rd_data),
		.lit_level  (white_q),
		.dark_level (black_q),
		.wr_en      (wr_en),
		.wr_pix     (wr_pix),
		.wr_data    (wr_data),
		.ctl_s3     (ctl_s3),
		.entry_s3   (entry_s3)
	);

	gcpd_convert #(
		.MAX_BITS (MAX_BITS)
	) u_convert (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.ctl_s3          (ctl_s3),
		.entry_s3        (entry_s3),
		.out_valid       (m_axis_tvalid),
		.out_pixel       (out_pixel),
		.code_valid      (code_valid),
		.stripe_position (stripe_position)
	);

	assign m_axis_tdata = {3'b000, stripe_position, out_pixel};
	assign m_axis_tuser = code_valid;

`ifndef ASSERT_OFF
	a_wr_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> en)
		else $error("code store written while pipeline stalled");

	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctl_s3.valid && ctl_s3.last && en))
		else $error("result word without a last-pattern item");

	a_flag_clears_code: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_data[MAX_BITS]) |-> (wr_data[MAX_BITS-1:0] == '0))
		else $error("invalid entry carries code bits");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctl_s3.valid && ctl_s3.last && entry_s3[MAX_BITS])
		|=> (m_axis_tvalid && !m_axis_tuser && stripe_position == '0))
		else $error("invalid code gave nonzero stripe");
`endif

endmodule
